[hdl/ptt_pkg.sv]
// types, constants and arithmetic helpers for the point-near-triangle test
`timescale 1ns / 1ps
package ptt_pkg;

  // field layout
  localparam int COORD_BITS = 21;
  localparam int NORM_BITS  = 21;
  localparam int FIELD_W    = 63;
  localparam int TOL_W      = 20;
  localparam int FRAC_SHIFT = 19;

  // configuration port
  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-3:0] REG_TOLERANCE = '0;
  localparam logic [TOL_W-1:0]  TOL_RESET     = TOL_W'(724);

  // datapath widths
  localparam int CW     = COORD_BITS;
  localparam int DW     = CW + 1;
  localparam int DN_W   = DW + NORM_BITS;
  localparam int DIST_W = DN_W + 2;
  localparam int DQ_W   = TOL_W + 2;
  localparam int NQ_W   = NORM_BITS + DQ_W;
  localparam int NQR_W  = NQ_W - FRAC_SHIFT;
  localparam int PR_W   = NQR_W + 1;
  localparam int Q_W    = PR_W + 1;
  localparam int QP_W   = 2 * Q_W;
  localparam int CR_W   = QP_W + 1;
  localparam int T2_W   = 2 * TOL_W;
  localparam int EP_W   = 2 * DW;
  localparam int EDOT_W = EP_W + 2;
  localparam int EX_W   = EP_W + 1;
  localparam int HALF   = 1 << (FRAC_SHIFT - 1);

  // wide multiplier split
  localparam int MW    = 54;
  localparam int ML    = 27;
  localparam int MH    = MW - ML;
  localparam int ACC_W = 2 * MW + 2;

  // cyclic component order for cross and dot products
  localparam int NEXT1 [3] = '{1, 2, 0};
  localparam int NEXT2 [3] = '{2, 0, 1};

  typedef logic signed [CW-1:0]        coord_t;
  typedef logic signed [NORM_BITS-1:0] norm_t;
  typedef logic [T2_W-1:0]             tol2_t;
  typedef logic signed [MW-1:0]        wop_t;
  typedef logic signed [ACC_W-1:0]     acc_t;

  typedef struct packed {
    logic [FIELD_W-1:0] unit_normal;
    logic [FIELD_W-1:0] vertex_c;
    logic [FIELD_W-1:0] vertex_b;
    logic [FIELD_W-1:0] vertex_a;
    logic [FIELD_W-1:0] query_point;
  } ptt_in_t;

  typedef struct packed {
    logic is_near;
    logic inside_face;
  } ptt_out_t;

  // partial products of one wide signed multiply
  typedef struct packed {
    logic signed [2*MH-1:0]  hh;
    logic signed [MH+ML:0]   hl;
    logic signed [MH+ML:0]   lh;
    logic [2*ML-1:0]         ll;
  } wpp_t;

  function automatic coord_t coord_at(logic [FIELD_W-1:0] v, int unsigned k);
    return v[k*CW +: CW];
  endfunction

  function automatic norm_t norm_at(logic [FIELD_W-1:0] v, int unsigned k);
    return v[k*NORM_BITS +: NORM_BITS];
  endfunction

  function automatic logic signed [DW-1:0] sub_c(coord_t a, coord_t b);
    logic signed [DW-1:0] x, y;
    x = a;
    y = b;
    return x - y;
  endfunction

  function automatic logic signed [DN_W-1:0] mul_dn(logic signed [DW-1:0] a, norm_t b);
    logic signed [DN_W-1:0] x, y;
    x = a;
    y = b;
    return x * y;
  endfunction

  function automatic logic signed [NQ_W-1:0] mul_nq(norm_t a, logic signed [DQ_W-1:0] b);
    logic signed [NQ_W-1:0] x, y;
    x = a;
    y = b;
    return x * y;
  endfunction

  function automatic logic signed [QP_W-1:0] mul_q(logic signed [Q_W-1:0] a,
                                                   logic signed [Q_W-1:0] b);
    logic signed [QP_W-1:0] x, y;
    x = a;
    y = b;
    return x * y;
  endfunction

  function automatic logic signed [EP_W-1:0] mul_e(logic signed [DW-1:0] a,
                                                   logic signed [DW-1:0] b);
    logic signed [EP_W-1:0] x, y;
    x = a;
    y = b;
    return x * y;
  endfunction

  // round half up, dropping all 19 fraction bits
  function automatic logic signed [DQ_W-1:0] round_dq(logic signed [DIST_W-1:0] d);
    logic signed [DIST_W-1:0] t;
    t = d + DIST_W'(HALF);
    return DQ_W'(t >>> FRAC_SHIFT);
  endfunction

  function automatic logic signed [NQR_W-1:0] round_nq(logic signed [NQ_W-1:0] d);
    logic signed [NQ_W-1:0] t;
    t = d + NQ_W'(HALF);
    return NQR_W'(t >>> FRAC_SHIFT);
  endfunction

  function automatic logic too_far(logic signed [DIST_W-1:0] d, logic [TOL_W-1:0] tol);
    logic [DIST_W-1:0] mag, lim;
    mag = d[DIST_W-1] ? DIST_W'(-d) : DIST_W'(d);
    lim = DIST_W'(tol) << FRAC_SHIFT;
    return mag > lim;
  endfunction

  function automatic wpp_t wmul_pp(wop_t a, wop_t b);
    logic signed [MH-1:0] ah, bh;
    logic [ML-1:0]        al, bl;
    wpp_t                 r;
    ah = a[MW-1:ML];
    bh = b[MW-1:ML];
    al = a[ML-1:0];
    bl = b[ML-1:0];
    r.hh = ah * bh;
    r.hl = ah * $signed({1'b0, bl});
    r.lh = $signed({1'b0, al}) * bh;
    r.ll = al * bl;
    return r;
  endfunction

  function automatic acc_t wpp_sum(wpp_t p);
    acc_t hh, hl, lh, ll;
    hh = p.hh;
    hl = p.hl;
    lh = p.lh;
    ll = p.ll;
    return (hh <<< (2 * ML)) + (hl <<< ML) + (lh <<< ML) + ll;
  endfunction

  // {positive, negative} of a three-term sum
  function automatic logic [1:0] sum3_sign(acc_t a, acc_t b, acc_t c);
    acc_t s;
    s = a + b + c;
    return {!s[ACC_W-1] && (s != '0), s[ACC_W-1]};
  endfunction

endpackage

[hdl/point_near_triangle_test.sv]
// top level of the pipelined point-near-triangle test
`timescale 1ns / 1ps
// usage
//   command channel: cmd_i carries the query point, the three vertices and the
//     unit normal; a transaction is taken at each clock edge where start is high
//     and busy is low. busy is always low, so one test enters every cycle that start is high.
//   result channel: done_o pulses for one cycle with res_o (is_near,
//     inside_face); results come out in command order, one per command.
//   pipeline: 13 pipeline registers lie between the accepting edge and done_o,
//     the longest path being the three face dot products, each a 106-bit
//     product built from partial products of 27-bit halves over two stages.
//   throughput: one transaction per cycle, sustained.
//   configuration: APB-style port, tolerance at byte address 0, reset 724.
//     write it only while the pipeline is empty.
//   reset: rst_ni clears the stage valid bits and reloads the tolerance;
//     nothing is in flight afterwards.
//   stalls: the receiver cannot hold results off, so the pipeline never stalls.
module point_near_triangle_test (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  ptt_pkg::ptt_in_t               cmd_i,
  output logic                           done_o,
  output ptt_pkg::ptt_out_t              res_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ptt_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import ptt_pkg::*;

  logic [TOL_W-1:0] tol_q;
  logic [13:1]      vld_q;
  logic             accept;

  // operand carry lines
  coord_t           p_q [1:5][3];
  coord_t           v_q [1:6][3][3];
  norm_t            n_q [1:4][3];
  logic [TOL_W-1:0] tp_q [1:3];
  tol2_t            t2_q;

  // plane distance and projection
  logic signed [DN_W-1:0]   dn_q [3];
  logic signed [DIST_W-1:0] dist_q;
  logic signed [DQ_W-1:0]   dq_q;
  logic [12:4]              rej_q;
  logic signed [NQ_W-1:0]   nq_q [3];
  logic signed [PR_W-1:0]   pr_q [3];
  logic signed [Q_W-1:0]    qv_q [3][3];

  // face test: cross products and their dot products
  logic signed [QP_W-1:0]   cp_q [3][3][2];
  logic signed [CR_W-1:0]   cr_q [3][3];
  wpp_t                     dpp_q [3][3];
  acc_t                     dprod_q [3][3];
  logic [2:0]               fpos_q, fneg_q;

  // edge tests
  logic [2:0]               edge_near;
  logic [12:9]              near_q;
  logic                     face;
  ptt_out_t                 res_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1:2] == REG_TOLERANCE) ? 32'(tol_q) : '0;

  // tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[ADDR_W-1:2] == REG_TOLERANCE)) begin
      tol_q <= pwdata[TOL_W-1:0];
    end
  end

  // valid bits travel alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[12:1], accept};
    end
  end

  // strictly inside when all three sign products agree
  assign face = (&fpos_q) || (&fneg_q);

  always_ff @(posedge clk_i) begin
    // stage 1: unpack the transaction, capture and square the tolerance
    for (int k = 0; k < 3; k++) begin
      p_q[1][k]    <= coord_at(cmd_i.query_point, k);
      v_q[1][0][k] <= coord_at(cmd_i.vertex_a, k);
      v_q[1][1][k] <= coord_at(cmd_i.vertex_b, k);
      v_q[1][2][k] <= coord_at(cmd_i.vertex_c, k);
      n_q[1][k]    <= norm_at(cmd_i.unit_normal, k);
    end
    tp_q[1] <= tol_q;
    t2_q    <= T2_W'(tol_q) * T2_W'(tol_q);

    for (int s = 2; s <= 5; s++) p_q[s] <= p_q[s-1];
    for (int s = 2; s <= 6; s++) v_q[s] <= v_q[s-1];
    for (int s = 2; s <= 4; s++) n_q[s] <= n_q[s-1];
    for (int s = 2; s <= 3; s++) tp_q[s] <= tp_q[s-1];

    // stage 2: (p - a) * n per axis
    for (int k = 0; k < 3; k++) begin
      dn_q[k] <= mul_dn(sub_c(p_q[1][k], v_q[1][0][k]), n_q[1][k]);
    end

    // stage 3: plane distance, 19 fraction bits
    dist_q <= DIST_W'(dn_q[0]) + DIST_W'(dn_q[1]) + DIST_W'(dn_q[2]);

    // stage 4: reject far points, round the distance
    rej_q[4] <= too_far(dist_q, tp_q[3]);
    dq_q     <= round_dq(dist_q);
    for (int s = 5; s <= 12; s++) rej_q[s] <= rej_q[s-1];

    // stage 5: offset along the normal
    for (int k = 0; k < 3; k++) begin
      nq_q[k] <= mul_nq(n_q[4][k], dq_q);
    end

    // stage 6: projection onto the plane
    for (int k = 0; k < 3; k++) begin
      pr_q[k] <= PR_W'(p_q[5][k]) - PR_W'(round_nq(nq_q[k]));
    end

    // stage 7: vertices relative to the projection
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        qv_q[i][k] <= Q_W'(v_q[6][i][k]) - Q_W'(pr_q[k]);
      end
    end

    // stage 8: cross product terms for q1xq2, q2xq3, q3xq1
    for (int c = 0; c < 3; c++) begin
      for (int j = 0; j < 3; j++) begin
        cp_q[c][j][0] <= mul_q(qv_q[c][NEXT1[j]], qv_q[NEXT1[c]][NEXT2[j]]);
        cp_q[c][j][1] <= mul_q(qv_q[c][NEXT2[j]], qv_q[NEXT1[c]][NEXT1[j]]);
      end
    end

    // stage 9: cross products
    for (int c = 0; c < 3; c++) begin
      for (int j = 0; j < 3; j++) begin
        cr_q[c][j] <= CR_W'(cp_q[c][j][0]) - CR_W'(cp_q[c][j][1]);
      end
    end

    // stage 10: partial products of c1.c2, c2.c3, c3.c1
    for (int d = 0; d < 3; d++) begin
      for (int j = 0; j < 3; j++) begin
        dpp_q[d][j] <= wmul_pp(MW'(cr_q[d][j]), MW'(cr_q[NEXT1[d]][j]));
      end
    end

    // stage 11: full products
    for (int d = 0; d < 3; d++) begin
      for (int j = 0; j < 3; j++) begin
        dprod_q[d][j] <= wpp_sum(dpp_q[d][j]);
      end
    end

    // stage 12: signs of the dot products
    for (int d = 0; d < 3; d++) begin
      {fpos_q[d], fneg_q[d]} <= sum3_sign(dprod_q[d][0], dprod_q[d][1], dprod_q[d][2]);
    end

    // edge results leave the edge units at stage 8
    near_q[9] <= |edge_near;
    for (int s = 10; s <= 12; s++) near_q[s] <= near_q[s-1];

    // stage 13: result register
    res_q.inside_face <= !rej_q[12] && face;
    res_q.is_near     <= !rej_q[12] && (face || near_q[12]);
  end

  // segments ab, bc, ac
  ptt_edge u_edge_ab (
    .clk_i  (clk_i),
    .p_i    (p_q[1]),
    .s_i    (v_q[1][0]),
    .e_i    (v_q[1][1]),
    .tol2_i (t2_q),
    .near_o (edge_near[0])
  );

  ptt_edge u_edge_bc (
    .clk_i  (clk_i),
    .p_i    (p_q[1]),
    .s_i    (v_q[1][1]),
    .e_i    (v_q[1][2]),
    .tol2_i (t2_q),
    .near_o (edge_near[1])
  );

  ptt_edge u_edge_ac (
    .clk_i  (clk_i),
    .p_i    (p_q[1]),
    .s_i    (v_q[1][0]),
    .e_i    (v_q[1][2]),
    .tol2_i (t2_q),
    .near_o (edge_near[2])
  );

  assign done_o = vld_q[13];
  assign res_o  = res_q;

`ifndef SYNTH
  // a face hit is always near
  a_face_near: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.inside_face |-> res_o.is_near)
    else $error("inside_face without is_near");

  // fixed latency from command to result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##13 done_o)
    else $error("result missing 13 cycles after transaction");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 13))
    else $error("result without a transaction");

  // plane rejection forces a far result
  a_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[12] && rej_q[12] |=> done_o && !res_o.is_near && !res_o.inside_face)
    else $error("rejected point reported near");
`endif

endmodule

[hdl/ptt_edge.sv]
// pipelined point to edge segment distance check against the squared tolerance
`timescale 1ns / 1ps
module ptt_edge (
  input  logic            clk_i,
  input  ptt_pkg::coord_t p_i [3],
  input  ptt_pkg::coord_t s_i [3],
  input  ptt_pkg::coord_t e_i [3],
  input  ptt_pkg::tol2_t  tol2_i,
  output logic            near_o
);
  import ptt_pkg::*;

  logic signed [DW-1:0]     w_q [3];
  logic signed [DW-1:0]     u_q [3];
  logic signed [DW-1:0]     q_q [3];
  tol2_t                    t2_q [2:4];
  logic signed [EP_W-1:0]   ww_p_q [3];
  logic signed [EP_W-1:0]   uu_p_q [3];
  logic signed [EP_W-1:0]   wu_p_q [3];
  logic signed [EP_W-1:0]   qq_p_q [3];
  logic signed [EP_W-1:0]   xa_q [3];
  logic signed [EP_W-1:0]   xb_q [3];
  logic signed [EDOT_W-1:0] ww_q, uu_q, wu_q, qq_q;
  logic signed [EX_W-1:0]   x_q [3];
  logic [7:5]               simp_q, wide_q;
  wpp_t                     tuu_pp_q;
  wpp_t                     xx_pp_q [3];
  acc_t                     tuu_q [6:7];
  acc_t                     xx_q [3];
  acc_t                     xs_q;
  logic                     near_q;
  logic signed [EDOT_W-1:0] t2e;
  logic                     short_e, past_end;
  acc_t                     margin;

  // end cases: degenerate edge or foot before the start, foot past the end
  always_comb begin
    t2e      = $signed(EDOT_W'(t2_q[4]));
    short_e  = (uu_q == '0) || wu_q[EDOT_W-1];
    past_end = wu_q > uu_q;
    margin   = tuu_q[7] - xs_q;
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      w_q[k] <= sub_c(p_i[k], s_i[k]);
      u_q[k] <= sub_c(e_i[k], s_i[k]);
      q_q[k] <= sub_c(p_i[k], e_i[k]);
    end
    t2_q[2] <= tol2_i;
    t2_q[3] <= t2_q[2];
    t2_q[4] <= t2_q[3];

    for (int k = 0; k < 3; k++) begin
      ww_p_q[k] <= mul_e(w_q[k], w_q[k]);
      uu_p_q[k] <= mul_e(u_q[k], u_q[k]);
      wu_p_q[k] <= mul_e(w_q[k], u_q[k]);
      qq_p_q[k] <= mul_e(q_q[k], q_q[k]);
      xa_q[k]   <= mul_e(w_q[NEXT1[k]], u_q[NEXT2[k]]);
      xb_q[k]   <= mul_e(w_q[NEXT2[k]], u_q[NEXT1[k]]);
    end

    ww_q <= EDOT_W'(ww_p_q[0]) + EDOT_W'(ww_p_q[1]) + EDOT_W'(ww_p_q[2]);
    uu_q <= EDOT_W'(uu_p_q[0]) + EDOT_W'(uu_p_q[1]) + EDOT_W'(uu_p_q[2]);
    wu_q <= EDOT_W'(wu_p_q[0]) + EDOT_W'(wu_p_q[1]) + EDOT_W'(wu_p_q[2]);
    qq_q <= EDOT_W'(qq_p_q[0]) + EDOT_W'(qq_p_q[1]) + EDOT_W'(qq_p_q[2]);
    for (int k = 0; k < 3; k++) begin
      x_q[k] <= EX_W'(xa_q[k]) - EX_W'(xb_q[k]);
    end

    simp_q[5] <= short_e ? (ww_q <= t2e) : (qq_q <= t2e);
    wide_q[5] <= !short_e && !past_end;
    tuu_pp_q  <= wmul_pp(MW'(t2_q[4]), MW'(uu_q));
    for (int k = 0; k < 3; k++) begin
      xx_pp_q[k] <= wmul_pp(MW'(x_q[k]), MW'(x_q[k]));
    end

    simp_q[6] <= simp_q[5];
    wide_q[6] <= wide_q[5];
    tuu_q[6]  <= wpp_sum(tuu_pp_q);
    for (int k = 0; k < 3; k++) begin
      xx_q[k] <= wpp_sum(xx_pp_q[k]);
    end

    simp_q[7] <= simp_q[6];
    wide_q[7] <= wide_q[6];
    tuu_q[7]  <= tuu_q[6];
    xs_q      <= xx_q[0] + xx_q[1] + xx_q[2];

    // interior foot: |w x u|^2 <= tol^2 * |u|^2
    near_q <= wide_q[7] ? !margin[ACC_W-1] : simp_q[7];
  end

  assign near_o = near_q;

endmodule

[dv/tb_point_near_triangle_test.sv]
// self-checking testbench for the point-near-triangle test block
`timescale 1ns / 1ps
module tb_point_near_triangle_test;
  import ptt_pkg::*;

  // exact signed arithmetic, wide enough for every product the test forms
  typedef logic signed [127:0] wide_t;
  typedef struct packed {
    wide_t x;
    wide_t y;
    wide_t z;
  } v3_t;

  localparam int    WATCHDOG_LIMIT = 4000;
  localparam int    DRAIN_CYCLES   = 16;
  localparam int    COORD_MAX      = (1 << (COORD_BITS - 1)) - 1;
  localparam int    UNIT           = 1 << FRAC_SHIFT;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  ptt_in_t           cmd_i;
  logic              done_o;
  ptt_out_t          res_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // shadow of the tolerance register as the block should hold it
  logic [TOL_W-1:0]  tol_shadow;
  ptt_out_t          verdict_q[$];
  int                n_errors;
  int                idle_cycles = 0;

  point_near_triangle_test dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd_i),
    .done_o  (done_o),
    .res_o   (res_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // geometry predictor
  // ---------------------------------------------------------------------------

  // three signed 21-bit lanes, x in the low bits
  function automatic v3_t unpack3(logic [FIELD_W-1:0] v);
    v3_t r;
    r.x = $signed(v[20:0]);
    r.y = $signed(v[41:21]);
    r.z = $signed(v[62:42]);
    return r;
  endfunction

  function automatic v3_t vsub(v3_t a, v3_t b);
    v3_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function automatic v3_t vcross(v3_t a, v3_t b);
    v3_t r;
    r.x = a.y * b.z - a.z * b.y;
    r.y = a.z * b.x - a.x * b.z;
    r.z = a.x * b.y - a.y * b.x;
    return r;
  endfunction

  function automatic wide_t vdot(v3_t a, v3_t b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  // drop 19 fraction bits, round half up
  function automatic wide_t round_frac(wide_t v);
    return (v + wide_t'(HALF)) >>> FRAC_SHIFT;
  endfunction

  function automatic int sign_of(wide_t v);
    if (v < 0) begin
      return -1;
    end
    return (v == 0) ? 0 : 1;
  endfunction

  // segment s..e within tolerance of p; a zero-length edge acts as point s
  function automatic bit edge_close(v3_t p, v3_t s, v3_t e, wide_t tol2);
    v3_t   w;
    v3_t   u;
    wide_t uu;
    wide_t wu;
    w  = vsub(p, s);
    u  = vsub(e, s);
    uu = vdot(u, u);
    wu = vdot(w, u);
    if (uu == 0 || wu < 0) begin
      return vdot(w, w) <= tol2;
    end
    if (wu > uu) begin
      return vdot(vsub(p, e), vsub(p, e)) <= tol2;
    end
    return tol2 * uu >= vdot(vcross(w, u), vcross(w, u));
  endfunction

  function automatic ptt_out_t predict_contact(ptt_in_t c, logic [TOL_W-1:0] tolv);
    v3_t      p, a, b, cc, n, pr, q1, q2, q3, c1, c2, c3;
    wide_t    tol, tol2, plane_d, mag, dq;
    int       f1, f2, f3;
    ptt_out_t r;
    p       = unpack3(c.query_point);
    a       = unpack3(c.vertex_a);
    b       = unpack3(c.vertex_b);
    cc      = unpack3(c.vertex_c);
    n       = unpack3(c.unit_normal);
    tol     = wide_t'(tolv);
    tol2    = tol * tol;
    plane_d = vdot(vsub(p, a), n);
    mag     = (plane_d < 0) ? -plane_d : plane_d;
    r       = '0;
    // too far from the plane: nothing else matters
    if (mag > (tol <<< FRAC_SHIFT)) begin
      return r;
    end
    dq   = round_frac(plane_d);
    pr.x = p.x - round_frac(n.x * dq);
    pr.y = p.y - round_frac(n.y * dq);
    pr.z = p.z - round_frac(n.z * dq);
    q1   = vsub(a, pr);
    q2   = vsub(b, pr);
    q3   = vsub(cc, pr);
    c1   = vcross(q1, q2);
    c2   = vcross(q2, q3);
    c3   = vcross(q3, q1);
    f1   = sign_of(vdot(c1, c2));
    f2   = sign_of(vdot(c2, c3));
    f3   = sign_of(vdot(c3, c1));
    if ((f1 > 0 && f2 > 0 && f3 > 0) || (f1 < 0 && f2 < 0 && f3 < 0)) begin
      r.is_near     = 1'b1;
      r.inside_face = 1'b1;
      return r;
    end
    r.is_near = edge_close(p, a, b, tol2) || edge_close(p, b, cc, tol2) ||
                edge_close(p, a, cc, tol2);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [FIELD_W-1:0] pack3(int x, int y, int z);
    logic [31:0] ux, uy, uz;
    ux = x;
    uy = y;
    uz = z;
    return {uz[20:0], uy[20:0], ux[20:0]};
  endfunction

  function automatic int clamp_coord(real v);
    int i;
    i = $rtoi(v);
    if (i > COORD_MAX) begin
      return COORD_MAX;
    end
    return (i < -COORD_MAX - 1) ? -COORD_MAX - 1 : i;
  endfunction

  function automatic int rand_signed(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [FIELD_W-1:0] rand_raw();
    return FIELD_W'({$urandom, $urandom});
  endfunction

  // a triangle with a matching unit normal and a point around it; the point
  // sits at barycentric spot (u,v), lifted off the plane by off along the normal
  function automatic ptt_in_t make_scene(int span, int off, real u, real v);
    int      ax, ay, az, bx, by, bz, cx, cy, cz;
    real     e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz, len;
    ptt_in_t t;
    ax  = rand_signed(span);
    ay  = rand_signed(span);
    az  = rand_signed(span);
    bx  = ax + rand_signed(span);
    by  = ay + rand_signed(span);
    bz  = az + rand_signed(span);
    cx  = ax + rand_signed(span);
    cy  = ay + rand_signed(span);
    cz  = az + rand_signed(span);
    e1x = bx - ax;
    e1y = by - ay;
    e1z = bz - az;
    e2x = cx - ax;
    e2y = cy - ay;
    e2z = cz - az;
    nx  = e1y * e2z - e1z * e2y;
    ny  = e1z * e2x - e1x * e2z;
    nz  = e1x * e2y - e1y * e2x;
    len = $sqrt(nx * nx + ny * ny + nz * nz);
    if (len == 0.0) begin
      len = 1.0;
    end
    nx = nx / len;
    ny = ny / len;
    nz = nz / len;
    t.vertex_a    = pack3(clamp_coord(ax), clamp_coord(ay), clamp_coord(az));
    t.vertex_b    = pack3(clamp_coord(bx), clamp_coord(by), clamp_coord(bz));
    t.vertex_c    = pack3(clamp_coord(cx), clamp_coord(cy), clamp_coord(cz));
    t.unit_normal = pack3(clamp_coord(nx * UNIT), clamp_coord(ny * UNIT),
                          clamp_coord(nz * UNIT));
    t.query_point = pack3(clamp_coord(ax + u * e1x + v * e2x + off * nx),
                          clamp_coord(ay + u * e1y + v * e2y + off * ny),
                          clamp_coord(az + u * e1z + v * e2z + off * nz));
    return t;
  endfunction

  function automatic real rand_bary();
    return ($itor($urandom_range(0, 1600)) / 1000.0) - 0.3;
  endfunction

  // ---------------------------------------------------------------------------
  // bus tasks
  // ---------------------------------------------------------------------------

  // one command transaction, after an idle gap whose length gap gives
  task automatic send_query(ptt_in_t item, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= item;
    forever begin
      @(negedge clk_i);
      if (!busy) break;
    end
    @(posedge clk_i);
    verdict_q = {verdict_q, predict_contact(item, tol_shadow)};
  endtask

  task automatic send_rand_gap(ptt_in_t item);
    // about two fifths of the items go back to back
    send_query(item, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8));
  endtask

  // lets every outstanding result come back before the register changes
  task automatic drain();
    start <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_tolerance(logic [TOL_W-1:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(REG_TOLERANCE) << 2;
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (pready) break;
    end
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    tol_shadow  = value;
    @(posedge clk_i);
  endtask

  task automatic check_tolerance_readback();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'(REG_TOLERANCE) << 2;
    @(posedge clk_i);
    penable <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (pready) break;
    end
    if (prdata[TOL_W-1:0] !== tol_shadow) begin
      $error("tolerance readback: expected %0d, actual %0d", tol_shadow,
             prdata[TOL_W-1:0]);
      n_errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // result checking: each done pulse is one transaction, compared in order
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    ptt_out_t want;
    if (rst_ni && done_o) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result: is_near %0b inside_face %0b", res_o.is_near,
               res_o.inside_face);
        n_errors++;
      end else begin
        want = verdict_q.pop_front();
        if (res_o.is_near !== want.is_near) begin
          $error("is_near: expected %0b, actual %0b", want.is_near, res_o.is_near);
          n_errors++;
        end
        if (res_o.inside_face !== want.inside_face) begin
          $error("inside_face: expected %0b, actual %0b", want.inside_face,
                 res_o.inside_face);
          n_errors++;
        end
      end
    end
  end

  // watchdog: counts cycles where no transaction moves in either direction
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset value of the register, then a handful of plain scenes with it
  task automatic test_reset_tolerance();
    check_tolerance_readback();
    repeat (4) send_rand_gap(make_scene(3000, rand_signed(1000), rand_bary(),
                                        rand_bary()));
  endtask

  // field extremes and raw patterns
  task automatic test_field_extremes();
    ptt_in_t t;
    write_tolerance('1);
    t = '0;
    send_query(t, 0);
    t = '1;
    send_query(t, 0);
    t.query_point = pack3(-COORD_MAX - 1, -COORD_MAX - 1, -COORD_MAX - 1);
    t.vertex_a    = pack3(COORD_MAX, COORD_MAX, COORD_MAX);
    t.vertex_b    = pack3(-COORD_MAX - 1, COORD_MAX, 0);
    t.vertex_c    = pack3(COORD_MAX, -COORD_MAX - 1, -COORD_MAX - 1);
    t.unit_normal = pack3(COORD_MAX, -COORD_MAX - 1, COORD_MAX);
    send_query(t, 1);
    // non-unit normal, largest magnitude on every lane
    t.unit_normal = pack3(-COORD_MAX - 1, -COORD_MAX - 1, -COORD_MAX - 1);
    send_query(t, 0);
    t.query_point = pack3(COORD_MAX, COORD_MAX, COORD_MAX);
    send_query(t, 2);
  endtask

  // plane rejection, face hit, and the regions beside, before and past an edge
  task automatic test_face_and_edges();
    ptt_in_t t;
    write_tolerance(TOL_RESET);
    // flat triangle in z = 0, normal +z
    t.vertex_a    = pack3(0, 0, 0);
    t.vertex_b    = pack3(8192, 0, 0);
    t.vertex_c    = pack3(0, 8192, 0);
    t.unit_normal = pack3(0, 0, UNIT);
    t.query_point = pack3(1000, 1000, 100);       // inside the face
    send_query(t, 0);
    t.query_point = pack3(1000, 1000, 724);       // exactly at the plane limit
    send_query(t, 0);
    t.query_point = pack3(1000, 1000, -725);      // just past it: rejected
    send_query(t, 3);
    t.query_point = pack3(4000, -500, 0);         // beside edge ab
    send_query(t, 0);
    t.query_point = pack3(-500, -500, 0);         // beyond the start of ab
    send_query(t, 0);
    t.query_point = pack3(8700, 0, 0);            // beyond the end of ab
    send_query(t, 0);
    t.query_point = pack3(5000, 5000, 0);         // beside bc, outside
    send_query(t, 0);
    t.query_point = pack3(-3000, 4000, 0);        // far from every edge
    send_query(t, 1);
    t.query_point = pack3(0, 0, 0);               // on a vertex: zero sign products
    send_query(t, 0);
  endtask

  // zero-length edges and a collinear face
  task automatic test_degenerate();
    ptt_in_t t;
    t.vertex_a    = pack3(500, 500, 0);
    t.vertex_b    = pack3(500, 500, 0);
    t.vertex_c    = pack3(3000, 500, 0);
    t.unit_normal = pack3(0, 0, UNIT);
    t.query_point = pack3(500, 900, 0);
    send_query(t, 0);
    t.vertex_c    = pack3(500, 500, 0);           // every edge collapsed
    t.query_point = pack3(900, 500, 0);
    send_query(t, 2);
    t.vertex_c    = pack3(4000, 500, 0);          // collinear, zero normal
    t.unit_normal = '0;
    t.query_point = pack3(2000, 700, 300);
    send_query(t, 0);
    t.query_point = pack3(2000, 500, 0);
    send_query(t, 0);
  endtask

  // random phases, one per entry of the tolerance set
  task automatic test_random_scenes();
    logic [TOL_W-1:0] tol_set[6];
    int               span;
    int               kind;
    ptt_in_t          t;
    tol_set = '{TOL_W'(0), '1, TOL_RESET, TOL_W'($urandom_range(1, 4096)),
                TOL_W'($urandom_range(0, (1 << TOL_W) - 1)), TOL_W'(1)};
    foreach (tol_set[ph]) begin
      write_tolerance(tol_set[ph]);
      repeat (92) begin
        kind = $urandom_range(0, 99);
        // mostly small triangles, a few large ones reaching about half the coordinate range
        span = ($urandom_range(0, 9) == 0) ? 250000 : $urandom_range(16, 6000);
        if (kind < 75) begin
          t = make_scene(span, rand_signed(2 * int'(tol_shadow) + 8), rand_bary(),
                         rand_bary());
        end else if (kind < 85) begin
          t = make_scene(span, rand_signed(64), rand_bary(), rand_bary());
          t.vertex_b = ($urandom_range(0, 1) != 0) ? t.vertex_a : t.vertex_c;
        end else begin
          t.query_point = rand_raw();
          t.vertex_a    = rand_raw();
          t.vertex_b    = rand_raw();
          t.vertex_c    = rand_raw();
          t.unit_normal = rand_raw();
        end
        send_rand_gap(t);
      end
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    start      = 1'b0;
    cmd_i      = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    tol_shadow = TOL_RESET;
    n_errors   = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_tolerance();
    test_field_extremes();
    test_face_and_edges();
    test_degenerate();
    test_random_scenes();

    drain();
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[point_near_triangle_test.f]
hdl/ptt_pkg.sv
hdl/ptt_edge.sv
hdl/point_near_triangle_test.sv
dv/tb_point_near_triangle_test.sv
